/* rtl/hwf_pkg.sv */
// Shared constants, types and the arctangent table for the hit window filter.
package hwf_pkg;

    // Default values for the top-level parameters.
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int MAX_HITS_DEF     = 4096;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed formats.
    localparam int GUARD_BITS = 8;    // extra fraction bits inside the rotator
    localparam int HEAD_BITS  = 3;    // headroom for the rotator gain
    localparam int REG_W      = 17;   // window register width
    localparam int COUNT_W    = 13;   // kept count field width
    localparam int ANGLE_W    = 25;   // angle accumulator, units of pi/2^23
    localparam int PHI_W      = 16;   // angle result, units of pi/32768
    localparam int CHUNK_W    = 16;   // operand slice of the gain multiplier
    localparam int INV_W      = 24;   // width of the inverse gain constant
    localparam int RND_SHIFT  = 32;   // fraction bits dropped after the gain
    localparam int CFG_IDX_W  = 3;

    localparam logic [INV_W-1:0]          INV_GAIN  = 24'd10188013;
    localparam logic signed [ANGLE_W-1:0] ANGLE_ROT = 25'sd4194304;  // pi/2
    localparam logic signed [ANGLE_W-1:0] ANGLE_RND = 25'sd128;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 25'sd32768;    // pi
    localparam logic [PHI_W-1:0]          PHI_MAX   = 16'd32768;

    // Register reset values.
    localparam logic signed [REG_W-1:0] WIN_MIN_RST = 17'sh10000;  // -65536
    localparam logic signed [REG_W-1:0] WIN_MAX_RST = 17'sh0FFFF;  //  65535

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX = 3'd4;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_VEC,
        S_MUL,
        S_DECIDE
    } t_state;

    // Rounded atan(2^-k) in units of pi/2^23; steps past the table add nothing.
    function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] k);
        logic signed [ANGLE_W-1:0] v;
        case (k)
            5'd0:    v = 25'sd2097152;
            5'd1:    v = 25'sd1238021;
            5'd2:    v = 25'sd654136;
            5'd3:    v = 25'sd332050;
            5'd4:    v = 25'sd166669;
            5'd5:    v = 25'sd83416;
            5'd6:    v = 25'sd41718;
            5'd7:    v = 25'sd20860;
            5'd8:    v = 25'sd10430;
            5'd9:    v = 25'sd5215;
            5'd10:   v = 25'sd2608;
            5'd11:   v = 25'sd1304;
            5'd12:   v = 25'sd652;
            5'd13:   v = 25'sd326;
            5'd14:   v = 25'sd163;
            5'd15:   v = 25'sd81;
            5'd16:   v = 25'sd41;
            5'd17:   v = 25'sd20;
            5'd18:   v = 25'sd10;
            5'd19:   v = 25'sd5;
            5'd20:   v = 25'sd3;
            5'd21:   v = 25'sd1;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/hwf_cordic.sv */
// Iterative CORDIC vectoring unit: one micro-rotation per clock cycle.
module hwf_cordic
    import hwf_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int W  = COORD_WIDTH + GUARD_BITS + HEAD_BITS,
    localparam int SW = $clog2(CORDIC_STEPS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    output logic                          o_done,
    output logic        [W-1:0]           o_mag,
    output logic        [PHI_W-1:0]       o_phi
);

    logic signed [W-1:0]       r_vx, n_vx;
    logic signed [W-1:0]       r_vy, n_vy;
    logic signed [ANGLE_W-1:0] r_acc, n_acc;
    logic        [SW-1:0]      r_step;
    logic                      r_busy;
    logic                      r_done;

    logic signed [W-1:0]       x_w, y_w, y_abs;
    logic signed [W-1:0]       dx, dy;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [ANGLE_W-1:0] phi_sum, phi_sh;

    // Scale the operands and fold the vector into the right half plane.
    assign x_w   = W'(i_x) <<< GUARD_BITS;
    assign y_w   = W'(i_y) <<< GUARD_BITS;
    assign y_abs = y_w[W-1] ? -y_w : y_w;

    // One shared shift-and-add step, direction from the sign of y.
    assign dx  = r_vy >>> r_step;
    assign dy  = r_vx >>> r_step;
    assign ang = atan_entry(5'(r_step));

    always_comb begin
        if (i_start) begin
            if (x_w[W-1]) begin
                n_vx  = y_abs;
                n_vy  = -x_w;
                n_acc = ANGLE_ROT;
            end else begin
                n_vx  = x_w;
                n_vy  = y_abs;
                n_acc = '0;
            end
        end else if (!r_vy[W-1]) begin
            n_vx  = r_vx + dx;
            n_vy  = r_vy - dy;
            n_acc = r_acc + ang;
        end else begin
            n_vx  = r_vx - dx;
            n_vy  = r_vy + dy;
            n_acc = r_acc - ang;
        end
    end

    // Datapath registers update on a start and on every working cycle.
    always_ff @(posedge i_clk) begin
        if (i_start || r_busy) begin
            r_vx  <= n_vx;
            r_vy  <= n_vy;
            r_acc <= n_acc;
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == SW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Round the angle to pi/32768 units and clamp it to [0, pi].
    assign phi_sum = r_acc + ANGLE_RND;
    assign phi_sh  = phi_sum >>> GUARD_BITS;

    always_comb begin
        if (phi_sh[ANGLE_W-1]) begin
            o_phi = '0;
        end else if (phi_sh > ANGLE_MAX) begin
            o_phi = PHI_MAX;
        end else begin
            o_phi = phi_sh[PHI_W-1:0];
        end
    end

    assign o_mag  = r_vx[W-1] ? '0 : r_vx;
    assign o_done = r_done;

endmodule

/* rtl/hwf_gain_mul.sv */
// Gain correction: multiplies the magnitude by the inverse CORDIC gain one slice per cycle.
module hwf_gain_mul
    import hwf_pkg::*;
#(
    parameter int MAG_W = COORD_WIDTH_DEF + GUARD_BITS + HEAD_BITS,
    localparam int NCH  = (MAG_W + CHUNK_W - 1) / CHUNK_W,
    localparam int PADW = NCH * CHUNK_W,
    localparam int AW   = PADW + INV_W,
    localparam int RW   = AW + 1 - RND_SHIFT,
    localparam int CNW  = (NCH > 1) ? $clog2(NCH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_done,
    output logic [RW-1:0]    o_radius
);

    localparam int PRW = CHUNK_W + INV_W;

    logic [PADW-1:0]    r_mag;
    logic [AW-1:0]      r_acc;
    logic [CNW-1:0]     r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [CHUNK_W-1:0] chunk;
    logic [PRW-1:0]     prod;
    logic [AW:0]        rounded;

    // Highest slice first, so the partial sum shifts up by one slice each cycle.
    assign chunk = r_mag[r_cnt*CHUNK_W +: CHUNK_W];
    assign prod  = PRW'(chunk) * PRW'(INV_GAIN);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= PADW'(i_mag);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << CHUNK_W) + AW'(prod);
        end
    end

    // Slice counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NCH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Round to nearest and drop the fraction bits.
    assign rounded  = (AW + 1)'(r_acc) + ((AW + 1)'(1) << (RND_SHIFT - 1));
    assign o_radius = rounded[AW:RND_SHIFT];
    assign o_done   = r_done;

endmodule

/* rtl/hit_window_filter_core.sv */
// Top level of the hit window filter: registers, sequencer, window compare and kept count.
// Only one hit is in work at a time; the next is taken the cycle after its result is loaded,
// and a finished result waits in the sequencer while the output is stalled.
// Synchronous active-low reset restores the full window, cartesian mode and a zero count.
module hit_window_filter_core
    import hwf_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int MAX_HITS     = MAX_HITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int IN_TDW  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDW = ((2 * COORD_WIDTH + COUNT_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // Hit stream in.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_TDW-1:0]    s_axis_tdata,   // hit_x, hit_y
    input  logic                 s_axis_tlast,   // last_hit
    // Result stream out.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_TDW-1:0]   m_axis_tdata,   // out_x, out_y, kept_count
    output logic                 m_axis_tuser,   // keep
    output logic                 m_axis_tlast    // out_last
);

    localparam int W     = COORD_WIDTH + GUARD_BITS + HEAD_BITS;
    localparam int NCH   = (W + CHUNK_W - 1) / CHUNK_W;
    localparam int RW    = NCH * CHUNK_W + INV_W + 1 - RND_SHIFT;
    localparam int CNTW  = $clog2(MAX_HITS + 1);
    localparam int MAXW0 = (RW > REG_W) ? RW : REG_W;
    localparam int MAXW1 = (MAXW0 > COORD_WIDTH) ? MAXW0 : COORD_WIDTH;
    localparam int CMPW  = MAXW1 + 1;

    t_state r_state, n_state;

    logic                          r_mode;
    logic signed [REG_W-1:0]       r_first_min, r_first_max;
    logic signed [REG_W-1:0]       r_second_min, r_second_max;

    logic signed [COORD_WIDTH-1:0] r_x, r_y;
    logic                          r_last;
    logic        [CNTW-1:0]        r_count, n_count;

    logic                          r_m_valid;
    logic        [COORD_WIDTH-1:0] r_out_x, r_out_y;
    logic        [COUNT_W-1:0]     r_out_cnt;
    logic                          r_out_keep, r_out_last;

    logic signed [COORD_WIDTH-1:0] in_x, in_y;
    logic                          in_accept, out_free, out_load;
    logic                          cordic_start, cordic_done, mul_done;
    logic        [W-1:0]           mag;
    logic        [PHI_W-1:0]       phi;
    logic        [RW-1:0]          radius;
    logic signed [CMPW-1:0]        c_r, c_phi, c_x, c_y;
    logic signed [CMPW-1:0]        c_fmin, c_fmax, c_smin, c_smax;
    logic                          cart_ok, polar_ok, origin, keep;
    logic        [CNTW+COUNT_W-1:0] cnt_wide;

    assign in_x      = s_axis_tdata[COORD_WIDTH-1:0];
    assign in_y      = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;

    // Configuration registers; writes are always taken, unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_first_min  <= WIN_MIN_RST;
            r_first_max  <= WIN_MAX_RST;
            r_second_min <= WIN_MIN_RST;
            r_second_max <= WIN_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:       r_mode       <= i_cfg_data[0];
                CFG_FIRST_MIN:  r_first_min  <= i_cfg_data;
                CFG_FIRST_MAX:  r_first_max  <= i_cfg_data;
                CFG_SECOND_MIN: r_second_min <= i_cfg_data;
                CFG_SECOND_MAX: r_second_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared rotator and gain multiplier.
    hwf_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (in_x),
        .i_y     (in_y),
        .o_done  (cordic_done),
        .o_mag   (mag),
        .o_phi   (phi)
    );

    hwf_gain_mul #(
        .MAG_W (W)
    ) u_gain_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_VEC && cordic_done),
        .i_mag    (mag),
        .o_done   (mul_done),
        .o_radius (radius)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = r_mode ? S_VEC : S_DECIDE;
                end
            end
            S_VEC: begin
                if (cordic_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        cordic_start  = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                cordic_start  = s_axis_tvalid && r_mode;
            end
            S_DECIDE: begin
                out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the hit while it is in work.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x    <= in_x;
            r_y    <= in_y;
            r_last <= s_axis_tlast;
        end
    end

    // Window compare on a common signed width.
    assign c_r    = CMPW'(radius);
    assign c_phi  = CMPW'(phi);
    assign c_x    = CMPW'(r_x);
    assign c_y    = CMPW'(r_y);
    assign c_fmin = CMPW'(r_first_min);
    assign c_fmax = CMPW'(r_first_max);
    assign c_smin = CMPW'(r_second_min);
    assign c_smax = CMPW'(r_second_max);

    assign cart_ok  = (c_y > c_fmin) && (c_y <= c_fmax) && (c_x > c_smin) && (c_x <= c_smax);
    assign polar_ok = (c_r >= c_fmin) && (c_r <= c_fmax)
                   && (c_phi >= c_smin) && (c_phi <= c_smax);
    assign origin   = (r_x == '0) && (r_y == '0);
    assign keep     = r_mode ? (polar_ok && !origin) : cart_ok;

    // Kept count saturates at the batch limit; the field shows its low bits.
    always_comb begin
        n_count = r_count;
        if (keep && (r_count < CNTW'(MAX_HITS))) begin
            n_count = r_count + 1'b1;
        end
    end

    assign cnt_wide = {COUNT_W'(0), n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (out_load) begin
            r_count <= r_last ? '0 : n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_keep <= keep;
            r_out_cnt  <= cnt_wide[COUNT_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDW'({r_out_cnt, r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_keep;
    assign m_axis_tlast  = r_out_last;

    // The kept count never passes the batch limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_HITS))
        else $error("kept count above batch limit");

    // The rotator finishes only while the sequencer waits for it.
    a_cordic_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == S_VEC))
        else $error("rotator finished outside the vectoring state");

    // A hit at the origin is never kept in polar mode.
    a_origin_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_mode && origin) |=> !m_axis_tuser)
        else $error("origin hit kept in polar mode");

    // After the last hit of a batch the count starts over.
    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> (r_count == '0))
        else $error("kept count not cleared after the last hit");

endmodule
